// ----- src/assert_macros.svh -----
// assertion macros used by fcs_back
// every macro samples on clk and is held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define FCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define FCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/fcs_pkg.sv -----
// types and constants for the compensated float sum block
// no dependencies
`timescale 1ns / 1ps

package fcs_pkg;

  localparam int unsigned FP_W = 64;

  // default quiet nan produced by invalid operations
  localparam logic [FP_W-1:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [FP_W-1:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [10:0]     EXP_ALL1    = 11'h7FF;

  typedef struct packed {
    logic [FP_W-1:0] sample_bits;
    logic            end_of_run;
  } item_t;

  // one operation for the shared adder: z = a + b, or a - b when sub is set
  typedef struct packed {
    logic            vld;
    logic [FP_W-1:0] a;
    logic [FP_W-1:0] b;
    logic            sub;
  } add_req_t;

  typedef struct packed {
    logic            vld;
    logic [FP_W-1:0] z;
  } add_rsp_t;

endpackage

// ----- src/fcs_if.sv -----
// channel interfaces for the compensated float sum block
// depends on fcs_pkg
`timescale 1ns / 1ps

interface fcs_in_if;
  logic                    valid;
  logic                    ready;
  logic [fcs_pkg::FP_W-1:0] sample_bits;
  logic                    end_of_run;
  modport source (output valid, output sample_bits, output end_of_run, input ready);
  modport sink   (input valid, input sample_bits, input end_of_run, output ready);
endinterface

interface fcs_out_if;
  logic                    valid;
  logic                    ready;
  logic [fcs_pkg::FP_W-1:0] total_bits;
  modport source (output valid, output total_bits, input ready);
  modport sink   (input valid, input total_bits, output ready);
endinterface

// ----- src/fcs_front.sv -----
// front end: accepts input items into a two-entry queue for the back end
// depends on fcs_pkg
`timescale 1ns / 1ps

module fcs_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  fcs_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_ready,
  output fcs_pkg::item_t q_item
);

  fcs_pkg::item_t mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_item;
  end

endmodule

// ----- src/fcs_fadd.sv -----
// four-stage binary64 adder, round to nearest even, subnormals kept
// depends on fcs_pkg
`timescale 1ns / 1ps

module fcs_fadd (
  input  logic               clk,
  input  logic               rst_n,
  input  fcs_pkg::add_req_t  req,
  output fcs_pkg::add_rsp_t  rsp
);

  function automatic logic [5:0] lzc57(input logic [56:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd57;
    found = 1'b0;
    for (int i = 56; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(56 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // stage 1: unpack, specials, swap, align
  logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_big;
  logic [10:0] ea, eb, ea_e, eb_e, e_big, e_sml, d;
  logic [55:0] m_big, m_sml, m_al;
  logic [5:0]  sh;
  logic        spec;
  logic [63:0] spec_val;

  always_comb begin
    sa    = req.a[63];
    sb    = req.b[63] ^ req.sub;
    ea    = req.a[62:52];
    eb    = req.b[62:52];
    a_nan = (ea == fcs_pkg::EXP_ALL1) && (req.a[51:0] != 52'd0);
    b_nan = (eb == fcs_pkg::EXP_ALL1) && (req.b[51:0] != 52'd0);
    a_inf = (ea == fcs_pkg::EXP_ALL1) && (req.a[51:0] == 52'd0);
    b_inf = (eb == fcs_pkg::EXP_ALL1) && (req.b[51:0] == 52'd0);
    spec     = a_nan || b_nan || a_inf || b_inf;
    spec_val = {sb, req.b[62:0]};
    if (a_nan) begin
      spec_val = req.a | fcs_pkg::QUIET_BIT;
    end else if (b_nan) begin
      spec_val = req.b | fcs_pkg::QUIET_BIT;
    end else if (a_inf && b_inf && (sa != sb)) begin
      spec_val = fcs_pkg::DEFAULT_NAN;
    end else if (a_inf) begin
      spec_val = req.a;
    end
    ea_e  = (ea == 11'd0) ? 11'd1 : ea;
    eb_e  = (eb == 11'd0) ? 11'd1 : eb;
    a_big = (req.a[62:0] >= req.b[62:0]);
    e_big = a_big ? ea_e : eb_e;
    e_sml = a_big ? eb_e : ea_e;
    m_big = a_big ? {(ea != 11'd0), req.a[51:0], 3'b000}
                  : {(eb != 11'd0), req.b[51:0], 3'b000};
    m_sml = a_big ? {(eb != 11'd0), req.b[51:0], 3'b000}
                  : {(ea != 11'd0), req.a[51:0], 3'b000};
    d     = e_big - e_sml;
    sh    = (d > 11'd63) ? 6'd63 : d[5:0];
    // shifted-out bits fold into the sticky position
    m_al  = (m_sml >> sh) | {55'd0, |(m_sml & ~({56{1'b1}} << sh))};
  end

  logic        s1_vld_r, s1_spec_r, s1_sign_r, s1_sub_r;
  logic [63:0] s1_sval_r;
  logic [10:0] s1_e_r;
  logic [55:0] s1_mb_r, s1_ma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= req.vld;
  end
  always_ff @(posedge clk) begin
    s1_spec_r <= spec;
    s1_sval_r <= spec_val;
    s1_sign_r <= a_big ? sa : sb;
    s1_sub_r  <= sa ^ sb;
    s1_e_r    <= e_big;
    s1_mb_r   <= m_big;
    s1_ma_r   <= m_al;
  end

  // stage 2: add or subtract magnitudes
  logic        s2_vld_r, s2_spec_r, s2_sign_r, s2_sub_r;
  logic [63:0] s2_sval_r;
  logic [10:0] s2_e_r;
  logic [56:0] s2_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end
  always_ff @(posedge clk) begin
    s2_spec_r <= s1_spec_r;
    s2_sval_r <= s1_sval_r;
    s2_sign_r <= s1_sign_r;
    s2_sub_r  <= s1_sub_r;
    s2_e_r    <= s1_e_r;
    s2_sum_r  <= s1_sub_r ? ({1'b0, s1_mb_r} - {1'b0, s1_ma_r})
                          : ({1'b0, s1_mb_r} + {1'b0, s1_ma_r});
  end

  // stage 3: leading zero count
  logic        s3_vld_r, s3_spec_r, s3_sign_r, s3_sub_r;
  logic [63:0] s3_sval_r;
  logic [10:0] s3_e_r;
  logic [56:0] s3_sum_r;
  logic [5:0]  s3_lz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
  end
  always_ff @(posedge clk) begin
    s3_spec_r <= s2_spec_r;
    s3_sval_r <= s2_sval_r;
    s3_sign_r <= s2_sign_r;
    s3_sub_r  <= s2_sub_r;
    s3_e_r    <= s2_e_r;
    s3_sum_r  <= s2_sum_r;
    s3_lz_r   <= lzc57(s2_sum_r);
  end

  // stage 4: normalise, round, pack
  logic [10:0] k;
  logic [11:0] e_res;
  logic [56:0] nrm;
  logic [10:0] e_enc;
  logic        g, st, inc;
  logic [62:0] mag;
  logic [63:0] z;

  always_comb begin
    k     = ({5'd0, s3_lz_r} > s3_e_r) ? s3_e_r : {5'd0, s3_lz_r};
    e_res = {1'b0, s3_e_r} + 12'd1 - {1'b0, k};
    nrm   = s3_sum_r << k;
    e_enc = nrm[56] ? e_res[10:0] : 11'd0;
    g     = nrm[3];
    st    = |nrm[2:0];
    inc   = g && (nrm[4] || st);
    mag   = {e_enc, nrm[55:4]} + {62'd0, inc};
    if (s3_spec_r) begin
      z = s3_sval_r;
    end else if (s3_sum_r == 57'd0) begin
      // exact cancellation gives +0, like-signed zeros keep their sign
      z = {(!s3_sub_r && s3_sign_r), 63'd0};
    end else if (e_res >= 12'h7FF) begin
      z = {s3_sign_r, fcs_pkg::EXP_ALL1, 52'd0};
    end else begin
      z = {s3_sign_r, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rsp.vld <= 1'b0;
    else        rsp.vld <= s3_vld_r;
    rsp.z <= z;
  end

endmodule

// ----- src/fcs_back.sv -----
// back end: sequences the four compensated additions per item on one adder
// depends on fcs_pkg, fcs_fadd, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fcs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  fcs_pkg::item_t q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [63:0]    out_total
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_Y    = 3'd1;
  localparam logic [2:0] ST_T    = 3'd2;
  localparam logic [2:0] ST_D    = 3'd3;
  localparam logic [2:0] ST_C    = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]  st_r, st_nxt;
  logic        issued_r, issued_nxt;
  logic [63:0] sum_r, comp_r, v_r, y_r, t_r, c_r;
  logic        eor_r;
  logic        out_vld_r;
  logic [63:0] out_r;
  logic        commit, take;
  logic        in_op;

  fcs_pkg::add_req_t req;
  fcs_pkg::add_rsp_t rsp;

  fcs_fadd u_fadd (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign in_op     = (st_r == ST_Y || st_r == ST_T || st_r == ST_D || st_r == ST_C);
  assign commit    = (st_r == ST_FIN) && (!eor_r || !out_vld_r || out_ready);
  assign take      = q_valid && q_ready;
  assign q_ready   = (st_r == ST_IDLE) || commit;
  assign out_valid = out_vld_r;
  assign out_total = out_r;

  always_comb begin
    req     = '0;
    req.vld = !issued_r && in_op;
    case (st_r)
      ST_Y: begin
        req.a = v_r; req.b = comp_r; req.sub = 1'b1;
      end
      ST_T: begin
        req.a = sum_r; req.b = y_r; req.sub = 1'b0;
      end
      ST_D: begin
        req.a = t_r; req.b = sum_r; req.sub = 1'b1;
      end
      ST_C: begin
        req.a = c_r; req.b = y_r; req.sub = 1'b1;
      end
      default: begin
        req.a = '0; req.b = '0; req.sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_nxt     = st_r;
    issued_nxt = issued_r;
    if (req.vld) issued_nxt = 1'b1;
    case (st_r)
      ST_IDLE: if (take) st_nxt = ST_Y;
      ST_Y:    if (rsp.vld) begin st_nxt = ST_T; issued_nxt = 1'b0; end
      ST_T:    if (rsp.vld) begin st_nxt = ST_D; issued_nxt = 1'b0; end
      ST_D:    if (rsp.vld) begin st_nxt = ST_C; issued_nxt = 1'b0; end
      ST_C:    if (rsp.vld) begin st_nxt = ST_FIN; issued_nxt = 1'b0; end
      ST_FIN:  if (commit) st_nxt = take ? ST_Y : ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      issued_r  <= 1'b0;
      out_vld_r <= 1'b0;
      sum_r     <= '0;
      comp_r    <= '0;
    end else begin
      st_r     <= st_nxt;
      issued_r <= issued_nxt;
      if (commit && eor_r) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (commit) begin
        if (eor_r) begin
          sum_r     <= '0;
          comp_r    <= '0;
        end else begin
          sum_r  <= t_r;
          comp_r <= c_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      v_r   <= q_item.sample_bits;
      eor_r <= q_item.end_of_run;
    end
    if (rsp.vld) begin
      case (st_r)
        ST_Y:    y_r <= rsp.z;
        ST_T:    t_r <= rsp.z;
        default: c_r <= rsp.z; // difference, then the new compensation
      endcase
    end
    if (commit && eor_r) out_r <= t_r;
  end

  `FCS_ASSERT(a_rsp_in_op, !rsp.vld || in_op, "adder result outside an operation")
  `FCS_ASSERT(a_rsp_issued, !rsp.vld || issued_r, "adder result without a request")
  `FCS_ASSERT_NEXT(a_no_overwrite, out_vld_r && !out_ready, out_vld_r && $stable(out_r), "pending total lost")
  `FCS_ASSERT_NEXT(a_clear_run, commit && eor_r, sum_r == 64'd0 && comp_r == 64'd0, "run not cleared")

endmodule

// ----- src/compensated_float_sum_core.sv -----
// channel        | direction | payload
// in_ch          | sink      | sample_bits[63:0], end_of_run
// out_ch         | source    | total_bits[63:0]
// each item runs four dependent additions through one 4-stage binary64 adder;
// each add waits for the adder result before the next is issued, so the back end
// handles one item at a time; a two-entry queue takes items while it has room.
// a finished total waits in an output register; the next run's last item stalls
// only if that register is still full. synchronous active-low reset, no clearing pass.
// depends on fcs_pkg, fcs_if, fcs_front, fcs_back
`timescale 1ns / 1ps

module compensated_float_sum_core (
  input  logic      clk,
  input  logic      rst_n,
  fcs_in_if.sink    in_ch,
  fcs_out_if.source out_ch
);

  fcs_pkg::item_t in_item, q_item;
  logic           q_valid, q_ready;

  assign in_item.sample_bits = in_ch.sample_bits;
  assign in_item.end_of_run  = in_ch.end_of_run;

  fcs_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_item),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  fcs_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_total(out_ch.total_bits)
  );

endmodule
